// ===== sv/warp_map_composer_macros.svh =====
// ----------------------------------------------------------------------------
// warp_map_composer_macros
// Assertion macros shared by the warp map composer RTL.
// ----------------------------------------------------------------------------
`ifndef WARP_MAP_COMPOSER_MACROS_SVH
`define WARP_MAP_COMPOSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define WMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define WMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/wmc_pkg.sv =====
// ----------------------------------------------------------------------------
// wmc_pkg
// Widths, register indexes and sizes of the warp map composer.
// ----------------------------------------------------------------------------
`default_nettype none

package wmc_pkg;
    localparam int VALUE_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int DIM_BITS   = 8;                 // map side up to 256
    localparam int SIZE_BITS  = DIM_BITS + 1;
    localparam int HALF_BITS  = DIM_BITS - 1;      // index inside one parity bank
    localparam int BANK_AW    = 2 * HALF_BITS;
    localparam int ENTRY_BITS = 2 * VALUE_BITS;    // row value low, column value high
    localparam int SCALE_BITS = VALUE_BITS + SIZE_BITS + 1;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR   = 4;
    localparam int CNT_BITS   = FIFO_PTR + 1;

    localparam logic [0:0] CFG_MAP_ROWS = 1'b0;
    localparam logic [0:0] CFG_MAP_COLS = 1'b1;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPOSE = 1'b1;

    localparam logic [SIZE_BITS-1:0] SIZE_MAX = SIZE_BITS'(1 << DIM_BITS);
    localparam logic [SIZE_BITS-1:0] SIZE_MIN = SIZE_BITS'(1);
endpackage

`default_nettype wire

// ===== sv/wmc_bank_ram.sv =====
// ----------------------------------------------------------------------------
// wmc_bank_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wmc_bank_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== sv/wmc_blend.sv =====
// ----------------------------------------------------------------------------
// wmc_blend
// Two-stage linear interpolation a + round((b - a) * t), ties upward.
// ----------------------------------------------------------------------------
`default_nettype none

module wmc_blend
    import wmc_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic signed [VALUE_BITS-1:0] i_a,
    input  wire logic signed [VALUE_BITS-1:0] i_b,
    input  wire logic        [FRAC_BITS-1:0]  i_t,
    output logic      signed [VALUE_BITS-1:0] o_y
);
    localparam int PW = VALUE_BITS + FRAC_BITS + 2;

    logic signed [VALUE_BITS:0]   diff;
    logic signed [PW-1:0]         r_p;
    logic signed [VALUE_BITS-1:0] r_a;
    logic signed [PW-1:0]         sum;
    logic signed [PW-1:0]         res;

    assign diff = (VALUE_BITS+1)'(i_b) - (VALUE_BITS+1)'(i_a);

    // stage 1: difference times weight
    always_ff @(posedge i_clk) begin
        r_a <= i_a;
        r_p <= PW'(diff) * $signed({1'b0, i_t});
    end

    // stage 2: round, floor shift, add base
    assign sum = r_p + PW'(1 << (FRAC_BITS - 1));
    assign res = PW'(r_a) + (sum >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        o_y <= res[VALUE_BITS-1:0];
    end
endmodule

`default_nettype wire

// ===== sv/wmc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// wmc_out_fifo
// Result queue between the compose pipeline and the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module wmc_out_fifo
    import wmc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [ENTRY_BITS-1:0] i_data,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output logic      [ENTRY_BITS-1:0] o_data
);
    logic [ENTRY_BITS-1:0] r_q [0:FIFO_DEPTH-1];
    logic [FIFO_PTR-1:0]   r_wr;
    logic [FIFO_PTR-1:0]   r_rd;
    logic [CNT_BITS-1:0]   r_fill;
    logic                  take;

    assign o_valid = (r_fill != '0);
    assign o_data  = r_q[r_rd];
    assign take    = o_valid && i_pop;

    // store pushed result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + FIFO_PTR'(1);
            if (take)   r_rd <= r_rd + FIFO_PTR'(1);
            r_fill <= r_fill + CNT_BITS'(i_push) - CNT_BITS'(take);
        end
    end
endmodule

`default_nettype wire

// ===== sv/warp_map_composer.sv =====
// Compose transfers pass capture, scale, bank read, row lerp and column lerp, then queue.
// Throughput: one item per cycle while tready is high; four parity banks (row and
// column parity) each serve one neighbour in the same cycle, so nothing is shared.
// Up to 16 compose items may be outstanding; the 16-entry result queue sets that.
// Reset (synchronous, active low): map_rows and map_cols return to 256, the
// queue empties; map contents are kept and are undefined until loaded.
// ----------------------------------------------------------------------------
// warp_map_composer
// Bilinear composition of two warp maps held in four banked memories.
// ----------------------------------------------------------------------------
`default_nettype none
`include "warp_map_composer_macros.svh"

module warp_map_composer
    import wmc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata: entry_row[7:0], entry_col[15:8], entry_row_value[39:16],
    //        entry_col_value[63:40], query_row_coord[87:64], query_col_coord[111:88]
    input  wire logic [111:0]          i_s_axis_tdata,
    // tuser: op[0]
    input  wire logic                  i_s_axis_tuser,
    // master stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata: out_row_value[23:0], out_col_value[47:24]
    output logic      [ENTRY_BITS-1:0] o_m_axis_tdata,
    // configuration write
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [0:0]            i_cfg_index,
    input  wire logic [SIZE_BITS-1:0]  i_cfg_data
);
    // ---------------- configuration ----------------
    logic [SIZE_BITS-1:0] r_rows, r_cols, cfg_eff;

    assign o_cfg_ready = 1'b1;
    assign cfg_eff = (i_cfg_data == '0) ? SIZE_MIN :
                     (i_cfg_data > SIZE_MAX) ? SIZE_MAX : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= SIZE_MAX;
            r_cols <= SIZE_MAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_ROWS: r_rows <= cfg_eff;
                CFG_MAP_COLS: r_cols <= cfg_eff;
                default: ;
            endcase
        end
    end

    // ---------------- admission ----------------
    logic                s_xfer, m_xfer;
    logic [CNT_BITS-1:0] r_count;

    assign o_s_axis_tready = (r_count != CNT_BITS'(FIFO_DEPTH));
    assign s_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign m_xfer = o_m_axis_tvalid && i_m_axis_tready;

    // track compose items in flight plus queued results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + CNT_BITS'(s_xfer && (i_s_axis_tuser == OP_COMPOSE))
                               - CNT_BITS'(m_xfer);
        end
    end

    // ---------------- stage 1: capture ----------------
    logic                         r1_v, r1_op;
    logic [DIM_BITS-1:0]          r1_erow, r1_ecol;
    logic [ENTRY_BITS-1:0]        r1_eval;
    logic signed [VALUE_BITS-1:0] r1_qrow, r1_qcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= s_xfer;
    end

    always_ff @(posedge i_clk) begin
        r1_op   <= i_s_axis_tuser;
        r1_erow <= i_s_axis_tdata[7:0];
        r1_ecol <= i_s_axis_tdata[15:8];
        r1_eval <= i_s_axis_tdata[63:16];
        r1_qrow <= i_s_axis_tdata[87:64];
        r1_qcol <= i_s_axis_tdata[111:88];
    end

    // ---------------- stage 2: scale ----------------
    logic                         r2_v, r2_op;
    logic [DIM_BITS-1:0]          r2_erow, r2_ecol;
    logic [ENTRY_BITS-1:0]        r2_eval;
    logic signed [SCALE_BITS-1:0] r2_srow, r2_scol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        r2_op   <= r1_op;
        r2_erow <= r1_erow;
        r2_ecol <= r1_ecol;
        r2_eval <= r1_eval;
        r2_srow <= SCALE_BITS'(r1_qrow) * $signed({1'b0, r_rows});
        r2_scol <= SCALE_BITS'(r1_qcol) * $signed({1'b0, r_cols});
    end

    // ---------------- stage 3: clamp, address, memory access ----------------
    localparam int CW = DIM_BITS + FRAC_BITS;

    logic [SIZE_BITS-1:0]         rows_m1, cols_m1;
    logic signed [SCALE_BITS-1:0] top_r, top_c;
    logic [CW-1:0]                cr, cc;
    logic [DIM_BITS-1:0]          i0, j0;
    logic [SIZE_BITS-1:0]         i1u, j1u;
    logic                         ci, cj, load_we;

    assign rows_m1 = r_rows - SIZE_BITS'(1);
    assign cols_m1 = r_cols - SIZE_BITS'(1);
    assign top_r = SCALE_BITS'({rows_m1[DIM_BITS-1:0], {FRAC_BITS{1'b0}}});
    assign top_c = SCALE_BITS'({cols_m1[DIM_BITS-1:0], {FRAC_BITS{1'b0}}});

    // clamp scaled coordinates to the map
    assign cr = r2_srow[SCALE_BITS-1] ? '0 :
                (r2_srow > top_r) ? top_r[CW-1:0] : r2_srow[CW-1:0];
    assign cc = r2_scol[SCALE_BITS-1] ? '0 :
                (r2_scol > top_c) ? top_c[CW-1:0] : r2_scol[CW-1:0];

    assign i0  = cr[CW-1:FRAC_BITS];
    assign j0  = cc[CW-1:FRAC_BITS];
    assign i1u = {1'b0, i0} + SIZE_BITS'(1);
    assign j1u = {1'b0, j0} + SIZE_BITS'(1);
    assign ci  = (i1u == r_rows);
    assign cj  = (j1u == r_cols);

    assign load_we = r2_v && (r2_op == OP_LOAD) &&
                     ({1'b0, r2_erow} < r_rows) && ({1'b0, r2_ecol} < r_cols);

    logic [ENTRY_BITS-1:0] rd [0:3];

    // one bank per row and column parity
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [DIM_BITS-1:0] rsel, csel;
        logic                we;

        assign rsel = (i0[0] == 1'(b / 2)) ? i0 : i1u[DIM_BITS-1:0];
        assign csel = (j0[0] == 1'(b % 2)) ? j0 : j1u[DIM_BITS-1:0];
        assign we   = load_we && (r2_erow[0] == 1'(b / 2)) && (r2_ecol[0] == 1'(b % 2));

        wmc_bank_ram #(
            .ADDR_W (BANK_AW),
            .DATA_W (ENTRY_BITS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr ({r2_erow[DIM_BITS-1:1], r2_ecol[DIM_BITS-1:1]}),
            .i_wdata (r2_eval),
            .i_raddr ({rsel[DIM_BITS-1:1], csel[DIM_BITS-1:1]}),
            .o_rdata (rd[b])
        );
    end

    logic                 r3_v, r3_ip, r3_jp, r3_ci, r3_cj;
    logic [FRAC_BITS-1:0] r3_ti, r3_tj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v && (r2_op == OP_COMPOSE);
    end

    always_ff @(posedge i_clk) begin
        r3_ip <= i0[0];
        r3_jp <= j0[0];
        r3_ci <= ci;
        r3_cj <= cj;
        r3_ti <= cr[FRAC_BITS-1:0];
        r3_tj <= cc[FRAC_BITS-1:0];
    end

    // ---------------- stages 4-5: lerp along rows ----------------
    logic                  fip, fjp;
    logic [ENTRY_BITS-1:0] v00, v10, v01, v11;

    // far neighbour falls back to the entry itself on the last row or column
    assign fip = r3_ci ? r3_ip : ~r3_ip;
    assign fjp = r3_cj ? r3_jp : ~r3_jp;
    assign v00 = rd[{r3_ip, r3_jp}];
    assign v10 = rd[{fip, r3_jp}];
    assign v01 = rd[{r3_ip, fjp}];
    assign v11 = rd[{fip, fjp}];

    logic signed [VALUE_BITS-1:0] ry0, ry1, cy0, cy1, ro, co;

    wmc_blend u_rb0 (.i_clk(i_clk), .i_a(v00[VALUE_BITS-1:0]), .i_b(v10[VALUE_BITS-1:0]),
                     .i_t(r3_ti), .o_y(ry0));
    wmc_blend u_rb1 (.i_clk(i_clk), .i_a(v01[VALUE_BITS-1:0]), .i_b(v11[VALUE_BITS-1:0]),
                     .i_t(r3_ti), .o_y(ry1));
    wmc_blend u_cb0 (.i_clk(i_clk), .i_a(v00[ENTRY_BITS-1:VALUE_BITS]),
                     .i_b(v10[ENTRY_BITS-1:VALUE_BITS]), .i_t(r3_ti), .o_y(cy0));
    wmc_blend u_cb1 (.i_clk(i_clk), .i_a(v01[ENTRY_BITS-1:VALUE_BITS]),
                     .i_b(v11[ENTRY_BITS-1:VALUE_BITS]), .i_t(r3_ti), .o_y(cy1));

    logic                 r4_v, r5_v, r6_v, r7_v;
    logic [FRAC_BITS-1:0] r4_tj, r5_tj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    // hold column weight alongside the row lerps
    always_ff @(posedge i_clk) begin
        r4_tj <= r3_tj;
        r5_tj <= r4_tj;
    end

    // ---------------- stages 6-7: lerp along columns ----------------
    wmc_blend u_rf (.i_clk(i_clk), .i_a(ry0), .i_b(ry1), .i_t(r5_tj), .o_y(ro));
    wmc_blend u_cf (.i_clk(i_clk), .i_a(cy0), .i_b(cy1), .i_t(r5_tj), .o_y(co));

    // ---------------- result queue ----------------
    wmc_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r7_v),
        .i_data  ({co, ro}),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata)
    );

    // ---------------- assertions ----------------
    `WMC_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CNT_BITS'(FIFO_DEPTH), "result count overflow")
    `WMC_ASSERT_NOW(a_out_owed, o_m_axis_tvalid, r_count != '0, "result without pending item")
    `WMC_ASSERT_NOW(a_push_owed, r7_v, r_count != '0, "pipeline result not accounted")
    `WMC_ASSERT_NEXT(a_count_up, s_xfer && i_s_axis_tuser && !m_xfer,
                     r_count == $past(r_count) + CNT_BITS'(1), "compose not counted")
endmodule

`default_nettype wire

// ===== tb/warp_map_composer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// warp_map_composer_checker
// Watches the config, input and result channels of the warp map composer,
// keeps its own copy of both maps and sizes, predicts the interpolated
// values of every compose transfer and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module warp_map_composer_checker
    import wmc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    input  wire logic [111:0]          i_s_tdata,
    input  wire logic                  i_s_tuser,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic [ENTRY_BITS-1:0] i_m_tdata,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [0:0]            i_cfg_index,
    input  wire logic [SIZE_BITS-1:0]  i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    typedef logic signed [VALUE_BITS-1:0] value_t;

    value_t                 row_map [0:65535];
    value_t                 col_map [0:65535];
    logic [SIZE_BITS-1:0]   rows_reg = SIZE_MAX;
    logic [SIZE_BITS-1:0]   cols_reg = SIZE_MAX;
    logic [ENTRY_BITS-1:0]  expected_pixels [$];
    int                     fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_pixels.size();

    function automatic int eff_size(logic [SIZE_BITS-1:0] s);
        if (s == 0) return 1;
        if (s > SIZE_MAX) return int'(SIZE_MAX);
        return int'(s);
    endfunction

    // scale a normalized coordinate, clamp it, split into index and weight
    function automatic void split_coord(value_t coord, int size,
                                        output int idx, output longint w);
        longint s, top;
        s   = longint'(coord) * size;
        top = longint'(size - 1) <<< FRAC_BITS;
        if (s < 0) s = 0;
        if (s > top) s = top;
        idx = int'(s >>> FRAC_BITS);
        w   = s & ((64'sd1 <<< FRAC_BITS) - 1);
    endfunction

    // rounded lerp, ties toward plus infinity
    function automatic longint lerp(longint a, longint b, longint t);
        return a + (((b - a) * t + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic value_t bilerp(bit col_sel, int i0, int i1, int j0, int j1,
                                      longint ti, longint tj);
        longint v00, v10, v01, v11;
        v00 = col_sel ? col_map[i0*256+j0] : row_map[i0*256+j0];
        v10 = col_sel ? col_map[i1*256+j0] : row_map[i1*256+j0];
        v01 = col_sel ? col_map[i0*256+j1] : row_map[i0*256+j1];
        v11 = col_sel ? col_map[i1*256+j1] : row_map[i1*256+j1];
        return value_t'(lerp(lerp(v00, v10, ti), lerp(v01, v11, ti), tj));
    endfunction

    // update the map model or queue a prediction on each accepted input transfer
    function automatic void take_item(logic op, logic [111:0] d);
        int     rows, cols, r, c, i0, j0, i1, j1;
        longint ti, tj;
        rows = eff_size(rows_reg);
        cols = eff_size(cols_reg);
        if (op == OP_LOAD) begin
            r = d[7:0];
            c = d[15:8];
            if (r < rows && c < cols) begin
                row_map[r*256+c] = d[39:16];
                col_map[r*256+c] = d[63:40];
            end
        end else begin
            split_coord(d[87:64], rows, i0, ti);
            split_coord(d[111:88], cols, j0, tj);
            i1 = (i0 + 1 < rows) ? i0 + 1 : rows - 1;
            j1 = (j0 + 1 < cols) ? j0 + 1 : cols - 1;
            expected_pixels.push_back({bilerp(1'b1, i0, i1, j0, j1, ti, tj),
                                       bilerp(1'b0, i0, i1, j0, j1, ti, tj)});
        end
    endfunction

    always @(posedge i_clk) begin
        logic [ENTRY_BITS-1:0] want;
        if (!i_rst_n) begin
            rows_reg <= SIZE_MAX;
            cols_reg <= SIZE_MAX;
            expected_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MAP_ROWS) rows_reg <= i_cfg_data;
                else cols_reg <= i_cfg_data;
            end
            // compare results before queuing new predictions
            if (i_m_tvalid && i_m_tready) begin
                if (expected_pixels.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result transfer: %h", i_m_tdata);
                end else begin
                    want = expected_pixels.pop_front();
                    if (want[23:0] != i_m_tdata[23:0] || want[47:24] != i_m_tdata[47:24]) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: row exp %h got %h, col exp %h got %h",
                                     want[23:0], i_m_tdata[23:0],
                                     want[47:24], i_m_tdata[47:24]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                take_item(i_s_tuser, i_s_tdata);
        end
    end
endmodule

`default_nettype wire

// ===== tb/warp_map_composer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// warp_map_composer_tb
// Drives size settings, map loads and compose pixels with bursty input and
// a stalling output; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module warp_map_composer_tb;
    import wmc_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [111:0]          s_tdata = '0;
    logic                  s_tuser = OP_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [ENTRY_BITS-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [0:0]            cfg_index = CFG_MAP_ROWS;
    logic [SIZE_BITS-1:0]  cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles = 0;
    int                    cur_rows = 256;
    int                    cur_cols = 256;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    warp_map_composer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    warp_map_composer_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern: phases of always-ready, random, and heavy stall
    always @(posedge i_clk) begin
        int phase;
        phase = ($time / 4000) % 3;
        if (phase == 0) m_tready <= 1'b1;
        else if (phase == 1) m_tready <= ($urandom_range(0, 1) == 1);
        else m_tready <= ($urandom_range(0, 3) == 0);
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    int burst_left = 0;

    // send one item, with random gaps between bursts
    task automatic send_item(logic op, logic [111:0] d);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        // sample ready mid-cycle, where it is settled, then take the accepting edge
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
        if (burst_left == 0 || $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic load_entry(int r, int c, logic [23:0] rv, logic [23:0] cv);
        send_item(OP_LOAD, {48'd0, cv, rv, 8'(c), 8'(r)});
    endtask

    task automatic compose_pixel(logic [23:0] qr, logic [23:0] qc);
        send_item(OP_COMPOSE, {qc, qr, 48'($urandom) ^ {24'($urandom), 24'($urandom)},
                               16'($urandom)});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [SIZE_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // fill the whole active map so no read touches an unwritten entry
    task automatic fill_map();
        for (int r = 0; r < cur_rows; r++)
            for (int c = 0; c < cur_cols; c++)
                load_entry(r, c, 24'($urandom), 24'($urandom));
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 65536));
            2: return -24'($urandom_range(1, 300000));
            default: return 24'($urandom_range(0, 70000));
        endcase
    endfunction

    task automatic set_sizes(int r, int c, logic [SIZE_BITS-1:0] rw, logic [SIZE_BITS-1:0] cw);
        write_cfg(CFG_MAP_ROWS, rw);
        write_cfg(CFG_MAP_COLS, cw);
        cur_rows = r;
        cur_cols = c;
    endtask

    initial begin
        int n_items;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 2x2 map with extreme values, ignored loads, edge coords
        set_sizes(2, 2, 9'd2, 9'd2);
        load_entry(0, 0, 24'h7FFFFF, 24'h800000);
        load_entry(0, 1, 24'h800000, 24'h7FFFFF);
        load_entry(1, 0, 24'h000000, 24'hFFFFFF);
        load_entry(1, 1, 24'hFFFFFF, 24'h000001);
        load_entry(2, 0, 24'h123456, 24'h654321);
        load_entry(255, 255, 24'hABCDEF, 24'hFEDCBA);
        compose_pixel(24'h000000, 24'h000000);
        compose_pixel(24'h010000, 24'h010000);
        compose_pixel(24'h008000, 24'h008000);
        compose_pixel(24'h7FFFFF, 24'h800000);
        compose_pixel(24'h800000, 24'h7FFFFF);
        compose_pixel(24'h00FFFF, 24'h000001);
        compose_pixel(24'h004000, 24'h00C000);
        drain();

        // zero sizes act as one, oversize acts as full
        set_sizes(1, 1, 9'd0, 9'd0);
        load_entry(0, 0, 24'h0ABCDE, 24'hF00001);
        compose_pixel(24'h00C000, 24'h7FFFFF);
        compose_pixel(24'h800000, 24'h004000);
        drain();
        set_sizes(256, 1, 9'h1FF, 9'd1);
        fill_map();
        compose_pixel(24'h00FFFF, 24'h008000);
        drain();

        // random phases over several sizes; full size appears once
        n_items = 0;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_sizes(256, 256, 9'd256, 9'd256);
                1: set_sizes(1, 16, 9'd1, 9'd16);
                2: set_sizes(16, 2, 9'd16, 9'd2);
                default: begin
                    int r, c;
                    r = $urandom_range(1, 12);
                    c = $urandom_range(1, 12);
                    set_sizes(r, c, 9'(r), 9'(c));
                end
            endcase
            if (ph == 0) begin
                // sparse corner region only: query coords stay within it
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        load_entry(r, c, 24'($urandom), 24'($urandom));
                for (int k = 0; k < 40; k++)
                    compose_pixel(24'($urandom_range(0, 600)),
                                  24'($urandom_range(0, 600)));
                drain();
                continue;
            end
            fill_map();
            for (int k = 0; k < 120; k++) begin
                if ($urandom_range(0, 3) == 0)
                    load_entry($urandom_range(0, 255) % (cur_rows + 2),
                               $urandom_range(0, 255), 24'($urandom), 24'($urandom));
                else
                    compose_pixel(rand_coord(), rand_coord());
            end
            n_items += 120;
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/wmc_pkg.sv
sv/wmc_bank_ram.sv
sv/wmc_blend.sv
sv/wmc_out_fifo.sv
sv/warp_map_composer.sv
tb/warp_map_composer_checker.sv
tb/warp_map_composer_tb.sv
